// ===== rtl/grid_cell_binning_engine_core_assert.svh =====
// Assertion macros for the grid cell binning engine.
// Uses clk_i and rst_ni of the module that includes it.
`ifndef GRID_CELL_BINNING_ENGINE_CORE_ASSERT_SVH
`define GRID_CELL_BINNING_ENGINE_CORE_ASSERT_SVH
// expr holds at every clock edge out of reset
`define GCBE_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
// post holds in the cycle after pre
`define GCBE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`endif

// ===== rtl/gcbe_pkg.sv =====
// Shared constants, types and codes of the grid cell binning engine.
// No dependencies.
package gcbe_pkg;
  localparam int DIM         = 4;
  localparam int MAX_CELLS   = 256;
  localparam int MAX_MEMBERS = 16;
  localparam int CW          = 16;
  localparam int PN_W        = 16;
  localparam int NUM_WORDS   = 3;
  localparam int WORD_W      = 64;
  localparam int WSEL_W      = 2;
  localparam int DC_W        = $clog2(DIM + 1);
  localparam int DI_W        = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int CELL_AW     = $clog2(MAX_CELLS);
  localparam int CNT_W       = $clog2(MAX_CELLS + 1);
  localparam int MEMB_AW     = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
  localparam int MCNT_W      = $clog2(MAX_MEMBERS + 1);
  localparam int STEP_W      = $clog2(CW);
  localparam logic [WORD_W-1:0] WIDTH_RESET = 64'h0100010001000100;

  localparam logic [1:0] CFG_WIDTH_0 = 2'd0;
  localparam logic [1:0] CFG_WIDTH_1 = 2'd1;
  localparam logic [1:0] CFG_WIDTH_2 = 2'd2;

  typedef enum logic [2:0] {
    ST_ADDED  = 3'd0,
    ST_NEW    = 3'd1,
    ST_MEMBER = 3'd2,
    ST_TFULL  = 3'd3,
    ST_MFULL  = 3'd4
  } status_e;

  typedef logic [DIM-1:0][CW-1:0] key_t;

  typedef struct packed {
    key_t            key;
    logic [PN_W-1:0] pnum;
    logic            sat;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_FIN, F_PUSH} front_state_e;

  typedef enum logic [2:0] {
    B_IDLE, B_SEARCH, B_CRD, B_CWAIT, B_MRD, B_MCMP, B_OUT
  } back_state_e;
endpackage

// ===== rtl/gcbe_front.sv =====
// Front end: width registers, per-coordinate quantizer and key assembly.
// Depends on gcbe_pkg; pushes finished points into gcbe_queue.
module gcbe_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [63:0]              cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [15:0]       coordinate_i,
  input  logic [15:0]              point_number_i,
  input  logic                     last_dimension_i,
  input  gcbe_pkg::qstat_t         qstat_i,
  output logic                     push_o,
  output gcbe_pkg::job_t           job_o
);
  import gcbe_pkg::*;

  front_state_e      state_q, state_d;
  logic [WORD_W-1:0] cfg_q [NUM_WORDS];
  logic [DC_W-1:0]   cnt_q, cnt_d;
  key_t              key_q, key_d;
  logic              sat_q, sat_d;
  logic              last_q, last_d;
  logic [PN_W-1:0]   pnum_q, pnum_d;
  logic              neg_q, neg_d;
  logic [CW-1:0]     w_q, w_d;
  logic [CW:0]       rem_q, rem_d;
  logic [CW-1:0]     quot_q, quot_d;
  logic [STEP_W-1:0] step_q, step_d;

  logic [WORD_W-1:0] wword;
  logic [CW-1:0]     wsel;
  logic [CW-1:0]     cmag;
  logic [CW:0]       rem_sh;
  logic              ge;
  logic              rnd;
  logic [CW:0]       qm;
  logic signed [CW+1:0] qs;

  assign wword  = cfg_q[WSEL_W'(cnt_q >> 2)];
  assign wsel   = wword[16*2'(cnt_q) +: CW];
  assign cmag   = coordinate_i[15] ? CW'(-coordinate_i) : CW'(coordinate_i);
  assign rem_sh = {rem_q[CW-1:0], quot_q[CW-1]};
  assign ge     = rem_sh >= {1'b0, w_q};
  assign rnd    = {rem_q[CW-1:0], 1'b0} > {1'b0, w_q};
  assign qm     = {1'b0, quot_q} + (CW+1)'(rnd);
  assign qs     = neg_q ? -$signed({1'b0, qm}) : $signed({1'b0, qm});

  assign in_stall_o = (state_q != F_IDLE);
  assign push_o     = (state_q == F_PUSH) && !qstat_i.full;
  assign job_o      = '{key: key_q, pnum: pnum_q, sat: sat_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    key_d   = key_q;
    sat_d   = sat_q;
    last_d  = last_q;
    pnum_d  = pnum_q;
    neg_d   = neg_q;
    w_d     = w_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    step_d  = step_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          pnum_d  = point_number_i;
          last_d  = last_dimension_i;
          state_d = last_dimension_i ? F_PUSH : F_IDLE;
          if (cnt_q < DC_W'(DIM)) begin
            if (wsel == '0) begin
              cnt_d = cnt_q + 1'b1;
              if (coordinate_i == '0) begin
                key_d[DI_W'(cnt_q)] = '0;
              end else begin
                sat_d = 1'b1;
                key_d[DI_W'(cnt_q)] = coordinate_i[15] ? 16'h8000 : 16'h7fff;
              end
            end else begin
              neg_d   = coordinate_i[15];
              w_d     = wsel;
              rem_d   = '0;
              quot_d  = cmag;
              step_d  = '0;
              state_d = F_DIV;
            end
          end
        end
      end
      F_DIV: begin
        rem_d  = ge ? rem_sh - {1'b0, w_q} : rem_sh;
        quot_d = {quot_q[CW-2:0], ge};
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(CW - 1)) begin
          state_d = F_FIN;
        end
      end
      F_FIN: begin
        cnt_d = cnt_q + 1'b1;
        if (qs > 18'sd32767) begin
          sat_d = 1'b1;
          key_d[DI_W'(cnt_q)] = 16'h7fff;
        end else if (qs < -18'sd32768) begin
          sat_d = 1'b1;
          key_d[DI_W'(cnt_q)] = 16'h8000;
        end else begin
          key_d[DI_W'(cnt_q)] = qs[CW-1:0];
        end
        state_d = last_q ? F_PUSH : F_IDLE;
      end
      F_PUSH: begin
        if (!qstat_i.full) begin
          cnt_d   = '0;
          key_d   = '0;
          sat_d   = 1'b0;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
      key_q   <= '0;
      sat_q   <= 1'b0;
      for (int i = 0; i < NUM_WORDS; i++) cfg_q[i] <= WIDTH_RESET;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      key_q   <= key_d;
      sat_q   <= sat_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_WIDTH_0: cfg_q[0] <= cfg_data_i;
          CFG_WIDTH_1: cfg_q[1] <= cfg_data_i;
          CFG_WIDTH_2: cfg_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    pnum_q <= pnum_d;
    neg_q  <= neg_d;
    w_q    <= w_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    step_q <= step_d;
  end
endmodule

// ===== rtl/gcbe_queue.sv =====
// Two-entry job queue between front end and back end.
// Depends on gcbe_pkg.
module gcbe_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  gcbe_pkg::job_t   job_i,
  input  logic             pop_i,
  output gcbe_pkg::job_t   job_o,
  output gcbe_pkg::qstat_t qstat_o
);
  import gcbe_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] fill_q;

  assign job_o         = mem_q[rp_q];
  assign qstat_o.full  = (fill_q == 2'd2);
  assign qstat_o.empty = (fill_q == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      fill_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      fill_q <= fill_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= job_i;
  end
endmodule

// ===== rtl/gcbe_back.sv =====
// Back end: cell table search, member list scan and result register.
// Depends on gcbe_pkg and grid_cell_binning_engine_core_assert.svh.
module gcbe_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gcbe_pkg::job_t   job_i,
  input  gcbe_pkg::qstat_t qstat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       cell_number_o,
  output logic [2:0]       status_o,
  output logic             index_saturated_o
);
  import gcbe_pkg::*;
  `include "grid_cell_binning_engine_core_assert.svh"

  localparam int MADDR_W = CELL_AW + MEMB_AW;

  key_t              tab_mem  [MAX_CELLS];
  logic [PN_W-1:0]   memb_mem [MAX_CELLS*MAX_MEMBERS];
  logic [MCNT_W-1:0] mcnt_mem [MAX_CELLS];

  back_state_e       state_q, state_d;
  job_t              job_q, job_d;
  logic [CNT_W-1:0]  cell_cnt_q, cell_cnt_d;
  logic [CNT_W-1:0]  issue_q, issue_d;
  logic [CNT_W-1:0]  cmp_q, cmp_d;
  logic              rv_q, rv_d;
  logic [CELL_AW-1:0] slot_q, slot_d;
  logic [MCNT_W-1:0] n_q, n_d;
  logic [MCNT_W-1:0] j_q, j_d;
  status_e           status_q, status_d;

  key_t              tab_rdata_q;
  logic [PN_W-1:0]   memb_rdata_q;
  logic [MCNT_W-1:0] mcnt_rdata_q;

  logic              tab_re, memb_re, mcnt_re;
  logic              new_cell_we, memb_we;
  logic [CELL_AW-1:0] tab_raddr;
  logic [MADDR_W-1:0] memb_raddr, memb_waddr;

  assign pop_o             = (state_q == B_IDLE) && !qstat_i.empty;
  assign out_valid_o       = (state_q == B_OUT);
  assign cell_number_o     = 8'(slot_q);
  assign status_o          = status_q;
  assign index_saturated_o = job_q.sat;

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    cell_cnt_d  = cell_cnt_q;
    issue_d     = issue_q;
    cmp_d       = cmp_q;
    rv_d        = rv_q;
    slot_d      = slot_q;
    n_d         = n_q;
    j_d         = j_q;
    status_d    = status_q;
    tab_re      = 1'b0;
    memb_re     = 1'b0;
    mcnt_re     = 1'b0;
    new_cell_we = 1'b0;
    memb_we     = 1'b0;
    tab_raddr   = issue_q[CELL_AW-1:0];
    memb_raddr  = {slot_q, j_q[MEMB_AW-1:0]};
    memb_waddr  = {slot_q, n_q[MEMB_AW-1:0]};
    unique case (state_q)
      B_IDLE: begin
        if (!qstat_i.empty) begin
          job_d   = job_i;
          issue_d = '0;
          rv_d    = 1'b0;
          state_d = B_SEARCH;
        end
      end
      B_SEARCH: begin
        if (rv_q && tab_rdata_q == job_q.key) begin
          slot_d  = cmp_q[CELL_AW-1:0];
          state_d = B_CRD;
        end else if (issue_q < cell_cnt_q) begin
          tab_re  = 1'b1;
          rv_d    = 1'b1;
          cmp_d   = issue_q;
          issue_d = issue_q + 1'b1;
        end else if (rv_q) begin
          rv_d = 1'b0;
        end else if (cell_cnt_q == CNT_W'(MAX_CELLS)) begin
          slot_d   = '0;
          status_d = ST_TFULL;
          state_d  = B_OUT;
        end else begin
          new_cell_we = 1'b1;
          slot_d      = cell_cnt_q[CELL_AW-1:0];
          cell_cnt_d  = cell_cnt_q + 1'b1;
          status_d    = ST_NEW;
          state_d     = B_OUT;
        end
      end
      B_CRD: begin
        mcnt_re = 1'b1;
        state_d = B_CWAIT;
      end
      B_CWAIT: begin
        n_d     = mcnt_rdata_q;
        j_d     = '0;
        state_d = B_MRD;
      end
      B_MRD: begin
        if (j_q < n_q) begin
          memb_re = 1'b1;
          state_d = B_MCMP;
        end else if (n_q == MCNT_W'(MAX_MEMBERS)) begin
          status_d = ST_MFULL;
          state_d  = B_OUT;
        end else begin
          memb_we  = 1'b1;
          status_d = ST_ADDED;
          state_d  = B_OUT;
        end
      end
      B_MCMP: begin
        if (memb_rdata_q == job_q.pnum) begin
          status_d = ST_MEMBER;
          state_d  = B_OUT;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = B_MRD;
        end
      end
      B_OUT: begin
        if (!out_stall_i) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_IDLE;
      cell_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      cell_cnt_q <= cell_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    issue_q  <= issue_d;
    cmp_q    <= cmp_d;
    rv_q     <= rv_d;
    slot_q   <= slot_d;
    n_q      <= n_d;
    j_q      <= j_d;
    status_q <= status_d;
  end

  always_ff @(posedge clk_i) begin
    if (new_cell_we) tab_mem[cell_cnt_q[CELL_AW-1:0]] <= job_q.key;
    if (tab_re) tab_rdata_q <= tab_mem[tab_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (new_cell_we) begin
      mcnt_mem[cell_cnt_q[CELL_AW-1:0]] <= MCNT_W'(1);
    end else if (memb_we) begin
      mcnt_mem[slot_q] <= n_q + 1'b1;
    end
    if (mcnt_re) mcnt_rdata_q <= mcnt_mem[slot_q];
  end

  always_ff @(posedge clk_i) begin
    if (new_cell_we) begin
      memb_mem[{cell_cnt_q[CELL_AW-1:0], MEMB_AW'(0)}] <= job_q.pnum;
    end else if (memb_we) begin
      memb_mem[memb_waddr] <= job_q.pnum;
    end
    if (memb_re) memb_rdata_q <= memb_mem[memb_raddr];
  end

  `GCBE_ASSERT_ALWAYS(a_cnt_max, cell_cnt_q <= CNT_W'(MAX_CELLS), "cell count overflow")
  `GCBE_ASSERT_NEXT(a_new_inc, new_cell_we, cell_cnt_q == $past(cell_cnt_q) + 1'b1, "bad count")
  `GCBE_ASSERT_ALWAYS(a_tfull_slot, !out_valid_o || status_q != ST_TFULL || slot_q == '0, "slot")
endmodule

// ===== rtl/grid_cell_binning_engine_core.sv =====
// Grid cell binning engine top level: front end, job queue and back end.
// Depends on gcbe_pkg, gcbe_front, gcbe_queue and gcbe_back.
// Each coordinate is accepted and then passes through the bit-serial divider
// of the front end (a zero width or an extra coordinate skips the divider);
// the last coordinate adds a push into the two-entry job queue. The back end
// searches the cell table per point (one table memory read per cycle),
// fetches the member count (states B_CRD and B_CWAIT), and scans each stored
// member (states B_MRD and B_MCMP), then holds the result until it is taken.
// While the back end works, the front end accepts until the queue is full.
// Memories are not cleared after reset; only written entries are read.
module grid_cell_binning_engine_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [63:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic signed [15:0] coordinate_i,
  input  logic [15:0]       point_number_i,
  input  logic              last_dimension_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        cell_number_o,
  output logic [2:0]        status_o,
  output logic              index_saturated_o
);
  import gcbe_pkg::*;

  job_t   fjob, qjob;
  qstat_t qstat;
  logic   push, pop;

  assign cfg_ready_o = 1'b1;

  gcbe_front u_front (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o,
    .coordinate_i, .point_number_i, .last_dimension_i,
    .qstat_i (qstat),
    .push_o  (push),
    .job_o   (fjob)
  );

  gcbe_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .job_i   (fjob),
    .pop_i   (pop),
    .job_o   (qjob),
    .qstat_o (qstat)
  );

  gcbe_back u_back (
    .clk_i, .rst_ni,
    .job_i   (qjob),
    .qstat_i (qstat),
    .pop_o   (pop),
    .out_valid_o, .out_stall_i,
    .cell_number_o, .status_o, .index_saturated_o
  );
endmodule

// ===== tb/tb_grid_cell_binning_engine_core.sv =====
// Self-checking testbench for grid_cell_binning_engine_core: quantization, cell lookup,
// member lists and the full-table and full-member cases, checked against a built-in predictor.
// Depends on gcbe_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_grid_cell_binning_engine_core;
  import gcbe_pkg::*;

  localparam logic [1:0] CFG_SPARE  = 2'd3;
  localparam int         SETTLE     = 400;
  localparam longint     CYCLE_CAP  = 3000000;

  typedef struct packed {
    logic [7:0] cell_slot;
    status_e    status;
    logic       sat;
  } bin_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i = CFG_WIDTH_0;
  logic [63:0]       cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic signed [15:0] coordinate_i = '0;
  logic [15:0]       point_number_i = '0;
  logic              last_dimension_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [7:0]        cell_number_o;
  logic [2:0]        status_o;
  logic              index_saturated_o;

  grid_cell_binning_engine_core dut (.*);

  logic [63:0]  widths [NUM_WORDS];
  logic [63:0]  cell_keys [MAX_CELLS];
  logic [15:0]  members [MAX_CELLS][MAX_MEMBERS];
  int           member_total [MAX_CELLS];
  int           cells_used;
  int           dim_next;
  logic [63:0]  key_build;
  bit           sat_build;
  bin_result_t  pending_bins [$];

  bit     quiet;
  int     errors, items_sent, bins_checked, cfg_writes;
  int     status_hits [5];
  longint cycles;

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) out_stall_i <= !quiet && ($urandom_range(99) < 34);

  function automatic logic [15:0] quantize_coord(int c, int w, inout bit sat);
    int q, r;
    if (w == 0) begin
      if (c == 0) return 16'd0;
      sat = 1'b1;
      return (c > 0) ? 16'h7fff : 16'h8000;
    end
    q = c / w;
    r = c - q * w;
    if (2 * r > w) q++;
    if (-2 * r > w) q--;
    if (q > 32767) begin sat = 1'b1; q = 32767; end
    if (q < -32768) begin sat = 1'b1; q = -32768; end
    return q[15:0];
  endfunction

  task automatic bin_coordinate(int c, logic [15:0] pnum, bit last);
    int w, slot, n;
    bit found, member;
    bin_result_t res;
    found = 0;
    member = 0;
    slot = 0;
    if (dim_next < DIM) begin
      w = int'((widths[dim_next / 4] >> (16 * (dim_next % 4))) & 64'hffff);
      key_build[16*dim_next +: 16] = quantize_coord(c, w, sat_build);
      dim_next++;
    end
    if (!last) return;
    for (int i = 0; i < cells_used; i++)
      if (!found && cell_keys[i] == key_build) begin
        found = 1;
        slot = i;
      end
    if (!found) begin
      if (cells_used >= MAX_CELLS) begin
        res.status = ST_TFULL;
        slot = 0;
      end else begin
        slot = cells_used;
        cell_keys[slot] = key_build;
        members[slot][0] = pnum;
        member_total[slot] = 1;
        cells_used++;
        res.status = ST_NEW;
      end
    end else begin
      n = member_total[slot];
      for (int j = 0; j < n; j++) if (members[slot][j] == pnum) member = 1;
      if (member) res.status = ST_MEMBER;
      else if (n >= MAX_MEMBERS) res.status = ST_MFULL;
      else begin
        members[slot][n] = pnum;
        member_total[slot] = n + 1;
        res.status = ST_ADDED;
      end
    end
    res.cell_slot = slot[7:0];
    res.sat = sat_build;
    pending_bins.push_back(res);
    dim_next = 0;
    key_build = '0;
    sat_build = 0;
  endtask

  always @(posedge clk_i) begin
    bin_result_t exp_bin;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_bins.size() == 0) begin
        $error("unexpected transaction: cell %0d status %0d", cell_number_o, status_o);
        errors++;
      end else begin
        exp_bin = pending_bins.pop_front();
        bins_checked++;
        status_hits[exp_bin.status]++;
        if (cell_number_o !== exp_bin.cell_slot) begin
          $error("cell_number: expected %0d, got %0d", exp_bin.cell_slot, cell_number_o);
          errors++;
        end
        if (status_o !== exp_bin.status) begin
          $error("status: expected %0d, got %0d", exp_bin.status, status_o);
          errors++;
        end
        if (index_saturated_o !== exp_bin.sat) begin
          $error("index_saturated: expected %0d, got %0d", exp_bin.sat, index_saturated_o);
          errors++;
        end
      end
    end
  end

  task automatic send_coordinate(int c, logic [15:0] pnum, bit last);
    int cs;
    cs = $signed(c[15:0]);
    if (!quiet && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    coordinate_i <= c[15:0];
    point_number_i <= pnum;
    last_dimension_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    bin_coordinate(cs, pnum, last);
  endtask

  task automatic send_point(int c0, int c1, int c2, int c3, logic [15:0] pnum);
    send_coordinate(c0, pnum, 0);
    send_coordinate(c1, pnum, 0);
    send_coordinate(c2, pnum, 0);
    send_coordinate(c3, pnum, 1);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_width(logic [1:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
    if (idx != CFG_SPARE) widths[idx] = data;
  endtask

  task automatic test_reset_widths();
    send_point(0, 0, 0, 0, 16'd0);
    send_point(0, 0, 0, 0, 16'hffff);
    send_point(0, 0, 0, 0, 16'hffff);
    send_point(32767, -32768, 128, -128, 16'h1234);
    send_point(384, -384, 127, -129, 16'h4321);
    send_coordinate(512, 16'h0055, 1);
    for (int i = 0; i < 6; i++) send_coordinate(i * 1000 - 2000, 16'h00aa, i == 5);
  endtask

  task automatic test_width_extremes();
    drain();
    write_width(CFG_WIDTH_0, 64'hffff_0001_0000_0100);
    write_width(CFG_WIDTH_1, 64'h0);
    write_width(CFG_WIDTH_2, 64'hffff_ffff_ffff_ffff);
    write_width(CFG_SPARE, 64'h0);
    send_point(0, 5, -32768, 32767, 16'h0001);
    send_point(-1, 32767, -32768, -32768, 16'h0002);
    send_point(7, -32768, 32767, 32767, 16'h0003);
    send_point(-7, 3, 0, 0, 16'h0004);
  endtask

  task automatic test_member_overflow();
    drain();
    write_width(CFG_WIDTH_0, {4{16'h0400}});
    for (int i = 0; i < MAX_MEMBERS + 3; i++)
      send_point(100, -100, 50, 0, 16'(32'h8000 + i));
    send_point(100, -100, 50, 0, 16'h8000);
  endtask

  task automatic test_random_points(int phases, int pts);
    logic [63:0] wv;
    int n;
    for (int p = 0; p < phases; p++) begin
      drain();
      for (int k = 0; k < NUM_WORDS; k++) begin
        wv = {$urandom, $urandom};
        for (int d = 0; d < 4; d++)
          case ($urandom_range(7))
            0: wv[16*d +: 16] = 16'h0;
            1: wv[16*d +: 16] = 16'hffff;
            2, 3: wv[16*d +: 16] = 16'(32'h1000 + $urandom_range(16'h4000));
            default: ;
          endcase
        write_width(k[1:0], wv);
      end
      for (int i = 0; i < pts; i++) begin
        quiet = (p == 1) && (i > pts / 2);
        n = ($urandom_range(9) == 0) ? $urandom_range(1, 7) : DIM;
        for (int d = 0; d < n; d++)
          send_coordinate(($urandom_range(3) == 0) ? $signed(16'($urandom))
                                                   : $urandom_range(1200) - 600,
                          ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40)),
                          d == n - 1);
      end
      quiet = 0;
    end
  endtask

  task automatic test_table_overflow();
    drain();
    write_width(CFG_WIDTH_0, 64'h0100_0100_0100_0001);
    for (int i = 0; i < MAX_CELLS + 20; i++) send_coordinate(i * 97 - 13000, 16'(i), 1);
    send_coordinate(-13000, 16'h7777, 1);
  endtask

  initial begin
    for (int k = 0; k < NUM_WORDS; k++) widths[k] = WIDTH_RESET;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_widths();
    test_width_extremes();
    test_member_overflow();
    test_random_points(4, 44);
    test_table_overflow();
    drain();
    $display("sent %0d coordinates, checked %0d results, %0d register writes",
             items_sent, bins_checked, cfg_writes);
    $display("added %0d new %0d member %0d table-full %0d members-full %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4]);
    if (errors == 0 && pending_bins.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/gcbe_pkg.sv
rtl/gcbe_front.sv
rtl/gcbe_queue.sv
rtl/gcbe_back.sv
rtl/grid_cell_binning_engine_core.sv
tb/tb_grid_cell_binning_engine_core.sv
